### design/tpq_pkg.sv
// Shared types and codes for the typed packet queue.
// No dependencies.
package tpq_pkg;

  localparam int VOL_W = 20;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_MISS = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] packet_handle;
    logic [15:0] packet_bytes;
    logic [3:0]  packet_type;
    logic        header_ok;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [15:0]      out_handle;
    logic [15:0]      out_bytes;
    logic [VOL_W-1:0] volume_now;
  } rsp_t;

  // One stored descriptor as held in the slot RAM.
  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] bytes;
    logic [3:0]  ptype;
    logic        hdr_ok;
  } slot_t;

endpackage

### design/tpq_req_if.sv
// Valid/ready channel that carries one queue request.
// Depends on tpq_pkg.
interface tpq_req_if;
  import tpq_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/tpq_rsp_if.sv
// Valid/ready channel that carries one queue response.
// Depends on tpq_pkg.
interface tpq_rsp_if;
  import tpq_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/typed_packet_queue_with_volume_limit.sv
// Typed packet queue: descriptors kept in arrival order in one slot RAM, with a
// byte budget. A get walks the RAM through its single read port, one slot per
// cycle: it scans up to the first match and then moves every younger slot down
// by one. A new request is taken while the previous response still waits in the
// output register.
module typed_packet_queue_with_volume_limit #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [tpq_pkg::VOL_W-1:0] cfg_wdata,
  tpq_req_if.sink               req,
  tpq_rsp_if.source             rsp
);
  import tpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_t;

  state_t           state;
  logic [VOL_W-1:0] max_volume;
  logic [VOL_W-1:0] total_volume;
  logic [CW-1:0]    entry_count;
  logic [AW-1:0]    ptr;
  logic [3:0]       req_type;
  status_t          res_status;
  logic [15:0]      res_handle;
  logic [15:0]      res_bytes;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  slot_t            ram_wdata;
  logic [AW-1:0]    ram_raddr;
  slot_t            ram_rdata;

  logic [CW-1:0]    ptr_inc;
  logic             more;
  logic             hit;
  logic             accept;
  logic [VOL_W:0]   put_sum;
  logic             put_full;
  logic             rsp_load;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign ptr_inc  = CW'(ptr) + CW'(1);
  assign more     = ptr_inc < entry_count;
  assign hit      = ram_rdata.hdr_ok && (ram_rdata.ptype == req_type);
  assign put_sum  = {1'b0, total_volume} + (VOL_W + 1)'(req.data.packet_bytes);
  assign put_full = (entry_count == CW'(DEPTH)) || (put_sum > {1'b0, max_volume});
  assign rsp_load = (state == S_DONE) && (!rsp.valid || rsp.ready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = entry_count[AW-1:0];
    ram_wdata = slot_t'{handle: req.data.packet_handle, bytes: req.data.packet_bytes,
                        ptype: req.data.packet_type, hdr_ok: req.data.header_ok};
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        ram_we = accept && !req.data.mode && !put_full;
      end
      S_SCAN: begin
        ram_raddr = ptr_inc[AW-1:0];
      end
      S_SHIFT: begin
        ram_raddr = ptr_inc[AW-1:0];
        ram_we    = 1'b1;
        ram_waddr = ptr - AW'(1);
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  tpq_ram #(.WIDTH($bits(slot_t)), .DEPTH(DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_volume   <= VOL_W'(65535);
      total_volume <= '0;
      entry_count  <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_volume <= cfg_wdata;
      end
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_handle <= '0;
            res_bytes  <= '0;
            req_type   <= req.data.packet_type;
            ptr        <= '0;
            if (!req.data.mode) begin
              state <= S_DONE;
              if (put_full) begin
                res_status <= ST_FULL;
              end else begin
                res_status   <= ST_OK;
                entry_count  <= entry_count + CW'(1);
                total_volume <= put_sum[VOL_W-1:0];
              end
            end else if (entry_count == '0) begin
              res_status <= ST_MISS;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_status   <= ST_OK;
            res_handle   <= ram_rdata.handle;
            res_bytes    <= ram_rdata.bytes;
            total_volume <= (total_volume >= VOL_W'(ram_rdata.bytes)) ?
                            total_volume - VOL_W'(ram_rdata.bytes) : '0;
            entry_count  <= entry_count - CW'(1);
            if (more) begin
              ptr   <= ptr_inc[AW-1:0];
              state <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end else if (more) begin
            ptr <= ptr_inc[AW-1:0];
          end else begin
            res_status <= ST_MISS;
            state      <= S_DONE;
          end
        end
        S_SHIFT: begin
          // entry_count is already one lower here, so compare against it plus one
          if (ptr_inc < entry_count + CW'(1)) begin
            ptr <= ptr_inc[AW-1:0];
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the response until the output register is free
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.data.status     <= res_status;
      rsp.data.out_handle <= res_handle;
      rsp.data.out_bytes  <= res_bytes;
      rsp.data.volume_now <= total_volume;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (entry_count == $past(entry_count) || entry_count == $past(entry_count) + CW'(1) ||
         entry_count == $past(entry_count) - CW'(1)))
    else $error("entry count moved by more than one");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.status != ST_OK) |->
    (rsp.data.out_handle == '0 && rsp.data.out_bytes == '0))
    else $error("failed transfer carries a descriptor");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.data.status == ST_OK || rsp.data.status == ST_FULL ||
                   rsp.data.status == ST_MISS))
    else $error("bad status code");

endmodule

### design/tpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
